### design/qpr_pkg.sv
`timescale 1ns / 1ps

package qpr_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int OFFSET_WIDTH = 16;
    localparam int LIMIT_WIDTH  = 47;

    // Nine samples need four growth bits; the scaled coefficients need eight.
    localparam int SUM_WIDTH  = SAMPLE_WIDTH + 4;
    localparam int COEF_WIDTH = SAMPLE_WIDTH + 8;
    localparam int PROD_WIDTH = 2 * COEF_WIDTH;
    localparam int CMP_WIDTH  = (PROD_WIDTH > LIMIT_WIDTH) ? PROD_WIDTH : LIMIT_WIDTH;

    // One quotient bit beyond the offset width, so that saturation sees overflow.
    localparam int QUO_BITS = OFFSET_WIDTH + 1;

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic signed [OFFSET_WIDTH-1:0] offset_t;
    typedef logic signed [SUM_WIDTH-1:0]    sum_t;
    typedef logic signed [COEF_WIDTH-1:0]   coef_t;
    typedef logic signed [PROD_WIDTH-1:0]   prod_t;
    typedef logic        [PROD_WIDTH-1:0]   mag_t;
    typedef logic        [LIMIT_WIDTH-1:0]  limit_t;
    typedef logic        [CMP_WIDTH-1:0]    cmp_t;
    typedef logic        [QUO_BITS-1:0]     quo_t;

    localparam quo_t QUO_POS_MAX = quo_t'((1 << (OFFSET_WIDTH - 1)) - 1);
    localparam quo_t QUO_NEG_MAX = quo_t'(1 << (OFFSET_WIDTH - 1));

    typedef struct packed {
        sample_t sample_r0_c0;
        sample_t sample_r0_c1;
        sample_t sample_r0_c2;
        sample_t sample_r1_c0;
        sample_t sample_r1_c1;
        sample_t sample_r1_c2;
        sample_t sample_r2_c0;
        sample_t sample_r2_c1;
        sample_t sample_r2_c2;
    } grid_word_t;

    typedef struct packed {
        offset_t offset_row;
        offset_t offset_col;
        logic    degenerate;
    } peak_word_t;

    typedef struct packed {
        prod_t bb;
        prod_t ac;
        prod_t cd;
        prod_t be;
        prod_t ae;
        prod_t bd;
    } prod_set_t;

    typedef struct packed {
        mag_t det_mag;
        mag_t nr_mag;
        mag_t nc_mag;
        logic row_neg;
        logic col_neg;
        logic degenerate;
    } fit_t;

endpackage

### design/qpr_front.sv
`timescale 1ns / 1ps

module qpr_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  qpr_pkg::grid_word_t   in_word,
    output logic                  out_valid,
    input  logic                  out_ready,
    output qpr_pkg::prod_set_t    out_prod
);

    localparam int NUM_STAGES = 3;

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES:0]   stage_ready;

    qpr_pkg::sum_t x00, x01, x02, x10, x11, x12, x20, x21, x22;
    qpr_pkg::sum_t s00_next, s10_next, s20_next, s01_next, s02_next, s11_next;
    qpr_pkg::sum_t s00_reg, s10_reg, s20_reg, s01_reg, s02_reg, s11_reg;

    qpr_pkg::coef_t a_next, b_next, c_next, d_next, e_next;
    qpr_pkg::coef_t a_reg, b_reg, c_reg, d_reg, e_reg;

    qpr_pkg::prod_set_t prod_next;
    qpr_pkg::prod_set_t prod_reg;

    // A stage may load when it is empty or when its word moves on this cycle.
    always_comb
    begin
        stage_ready[NUM_STAGES] = out_ready;
        for (int i = NUM_STAGES - 1; i >= 0; i--)
        begin
            stage_ready[i] = !valid_reg[i] || stage_ready[i+1];
        end
    end

    assign in_ready  = stage_ready[0];
    assign out_valid = valid_reg[NUM_STAGES-1];
    assign out_prod  = prod_reg;

    assign x00 = qpr_pkg::sum_t'(in_word.sample_r0_c0);
    assign x01 = qpr_pkg::sum_t'(in_word.sample_r0_c1);
    assign x02 = qpr_pkg::sum_t'(in_word.sample_r0_c2);
    assign x10 = qpr_pkg::sum_t'(in_word.sample_r1_c0);
    assign x11 = qpr_pkg::sum_t'(in_word.sample_r1_c1);
    assign x12 = qpr_pkg::sum_t'(in_word.sample_r1_c2);
    assign x20 = qpr_pkg::sum_t'(in_word.sample_r2_c0);
    assign x21 = qpr_pkg::sum_t'(in_word.sample_r2_c1);
    assign x22 = qpr_pkg::sum_t'(in_word.sample_r2_c2);

    // Moments of the grid over row offset m and column offset n.
    assign s00_next = x00 + x01 + x02 + x10 + x11 + x12 + x20 + x21 + x22;
    assign s10_next = (x20 + x21 + x22) - (x00 + x01 + x02);
    assign s20_next = x00 + x01 + x02 + x20 + x21 + x22;
    assign s01_next = (x02 + x12 + x22) - (x00 + x10 + x20);
    assign s02_next = x00 + x10 + x20 + x02 + x12 + x22;
    assign s11_next = (x00 + x22) - (x02 + x20);

    // Coefficients scaled by 12 so that they stay integers.
    always_comb
    begin
        a_next = (qpr_pkg::coef_t'(s20_reg) <<< 2) + (qpr_pkg::coef_t'(s20_reg) <<< 1)
               - (qpr_pkg::coef_t'(s00_reg) <<< 2);
        c_next = (qpr_pkg::coef_t'(s02_reg) <<< 2) + (qpr_pkg::coef_t'(s02_reg) <<< 1)
               - (qpr_pkg::coef_t'(s00_reg) <<< 2);
        b_next = (qpr_pkg::coef_t'(s11_reg) <<< 1) + qpr_pkg::coef_t'(s11_reg);
        d_next = qpr_pkg::coef_t'(s10_reg) <<< 1;
        e_next = qpr_pkg::coef_t'(s01_reg) <<< 1;
    end

    always_comb
    begin
        prod_next.bb = qpr_pkg::prod_t'(b_reg) * qpr_pkg::prod_t'(b_reg);
        prod_next.ac = qpr_pkg::prod_t'(a_reg) * qpr_pkg::prod_t'(c_reg);
        prod_next.cd = qpr_pkg::prod_t'(c_reg) * qpr_pkg::prod_t'(d_reg);
        prod_next.be = qpr_pkg::prod_t'(b_reg) * qpr_pkg::prod_t'(e_reg);
        prod_next.ae = qpr_pkg::prod_t'(a_reg) * qpr_pkg::prod_t'(e_reg);
        prod_next.bd = qpr_pkg::prod_t'(b_reg) * qpr_pkg::prod_t'(d_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (stage_ready[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int i = 1; i < NUM_STAGES; i++)
            begin
                if (stage_ready[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready[0])
        begin
            s00_reg <= s00_next;
            s10_reg <= s10_next;
            s20_reg <= s20_next;
            s01_reg <= s01_next;
            s02_reg <= s02_next;
            s11_reg <= s11_next;
        end
        if (stage_ready[1])
        begin
            a_reg <= a_next;
            b_reg <= b_next;
            c_reg <= c_next;
            d_reg <= d_next;
            e_reg <= e_next;
        end
        if (stage_ready[2])
        begin
            prod_reg <= prod_next;
        end
    end

endmodule

### design/qpr_combine.sv
`timescale 1ns / 1ps

module qpr_combine (
    input  logic                  clk,
    input  logic                  rst_n,
    input  qpr_pkg::limit_t       limit,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  qpr_pkg::prod_set_t    in_prod,
    output logic                  out_valid,
    input  logic                  out_ready,
    output qpr_pkg::fit_t         out_fit
);

    localparam int NUM_STAGES = 3;

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES:0]   stage_ready;

    qpr_pkg::prod_t det_next, nr_next, nc_next;
    qpr_pkg::prod_t det_reg, nr_reg, nc_reg;

    qpr_pkg::mag_t  det_mag_next, nr_mag_next, nc_mag_next;
    qpr_pkg::mag_t  det_mag_reg, nr_mag_reg, nc_mag_reg;
    logic           row_neg_next, col_neg_next;
    logic           row_neg_reg, col_neg_reg;

    qpr_pkg::fit_t  fit_next;
    qpr_pkg::fit_t  fit_reg;

    always_comb
    begin
        stage_ready[NUM_STAGES] = out_ready;
        for (int i = NUM_STAGES - 1; i >= 0; i--)
        begin
            stage_ready[i] = !valid_reg[i] || stage_ready[i+1];
        end
    end

    assign in_ready  = stage_ready[0];
    assign out_valid = valid_reg[NUM_STAGES-1];
    assign out_fit   = fit_reg;

    // Scaled determinant and the two numerators of the stationary point.
    always_comb
    begin
        det_next = in_prod.bb - (in_prod.ac <<< 2);
        nr_next  = (in_prod.cd <<< 1) - in_prod.be;
        nc_next  = (in_prod.ae <<< 1) - in_prod.bd;
    end

    always_comb
    begin
        det_mag_next = det_reg[qpr_pkg::PROD_WIDTH-1] ? qpr_pkg::mag_t'(-det_reg)
                                                      : qpr_pkg::mag_t'(det_reg);
        nr_mag_next  = nr_reg[qpr_pkg::PROD_WIDTH-1]  ? qpr_pkg::mag_t'(-nr_reg)
                                                      : qpr_pkg::mag_t'(nr_reg);
        nc_mag_next  = nc_reg[qpr_pkg::PROD_WIDTH-1]  ? qpr_pkg::mag_t'(-nc_reg)
                                                      : qpr_pkg::mag_t'(nc_reg);
        row_neg_next = nr_reg[qpr_pkg::PROD_WIDTH-1] ^ det_reg[qpr_pkg::PROD_WIDTH-1];
        col_neg_next = nc_reg[qpr_pkg::PROD_WIDTH-1] ^ det_reg[qpr_pkg::PROD_WIDTH-1];
    end

    // A zero determinant is degenerate even when the limit is zero.
    always_comb
    begin
        fit_next.det_mag    = det_mag_reg;
        fit_next.nr_mag     = nr_mag_reg;
        fit_next.nc_mag     = nc_mag_reg;
        fit_next.row_neg    = row_neg_reg;
        fit_next.col_neg    = col_neg_reg;
        fit_next.degenerate = (det_mag_reg == '0)
                           || (qpr_pkg::cmp_t'(det_mag_reg) < qpr_pkg::cmp_t'(limit));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (stage_ready[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int i = 1; i < NUM_STAGES; i++)
            begin
                if (stage_ready[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready[0])
        begin
            det_reg <= det_next;
            nr_reg  <= nr_next;
            nc_reg  <= nc_next;
        end
        if (stage_ready[1])
        begin
            det_mag_reg <= det_mag_next;
            nr_mag_reg  <= nr_mag_next;
            nc_mag_reg  <= nc_mag_next;
            row_neg_reg <= row_neg_next;
            col_neg_reg <= col_neg_next;
        end
        if (stage_ready[2])
        begin
            fit_reg <= fit_next;
        end
    end

endmodule

### design/qpr_divider.sv
`timescale 1ns / 1ps

module qpr_divider #(
    parameter int FRAC_BITS = 14
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  qpr_pkg::fit_t         in_fit,
    output logic                  out_valid,
    input  logic                  out_ready,
    output qpr_pkg::peak_word_t   out_word
);

    localparam int QB         = qpr_pkg::QUO_BITS;
    localparam int REM_WIDTH  = qpr_pkg::PROD_WIDTH + FRAC_BITS + QB;
    // One stage for the overflow check, one per quotient bit, one for the output.
    localparam int NUM_STAGES = QB + 2;

    typedef logic [REM_WIDTH-1:0] rem_t;

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES:0]   stage_ready;

    rem_t        rem_row_reg [0:QB];
    rem_t        rem_col_reg [0:QB];
    rem_t        div_reg     [0:QB];
    qpr_pkg::quo_t q_row_reg [0:QB];
    qpr_pkg::quo_t q_col_reg [0:QB];
    logic        ovf_row_reg [0:QB];
    logic        ovf_col_reg [0:QB];
    logic        row_neg_reg [0:QB];
    logic        col_neg_reg [0:QB];
    logic        degen_reg   [0:QB];

    rem_t        num_row_in, num_col_in, div_in;

    qpr_pkg::peak_word_t word_next;
    qpr_pkg::peak_word_t word_reg;

    function automatic qpr_pkg::offset_t sat_offset(input qpr_pkg::quo_t q,
                                                    input logic ovf,
                                                    input logic neg);
        qpr_pkg::offset_t res;
        if (!neg)
        begin
            if (ovf || q > qpr_pkg::QUO_POS_MAX)
            begin
                res = qpr_pkg::offset_t'(qpr_pkg::QUO_POS_MAX);
            end
            else
            begin
                res = qpr_pkg::offset_t'(q);
            end
        end
        else
        begin
            if (ovf || q > qpr_pkg::QUO_NEG_MAX)
            begin
                res = qpr_pkg::offset_t'(qpr_pkg::QUO_NEG_MAX);
            end
            else
            begin
                res = qpr_pkg::offset_t'(qpr_pkg::OFFSET_WIDTH'(0)
                                         - q[qpr_pkg::OFFSET_WIDTH-1:0]);
            end
        end
        return res;
    endfunction

    always_comb
    begin
        stage_ready[NUM_STAGES] = out_ready;
        for (int i = NUM_STAGES - 1; i >= 0; i--)
        begin
            stage_ready[i] = !valid_reg[i] || stage_ready[i+1];
        end
    end

    assign in_ready  = stage_ready[0];
    assign out_valid = valid_reg[NUM_STAGES-1];
    assign out_word  = word_reg;

    assign num_row_in = rem_t'(in_fit.nr_mag) << FRAC_BITS;
    assign num_col_in = rem_t'(in_fit.nc_mag) << FRAC_BITS;
    assign div_in     = rem_t'(in_fit.det_mag);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (stage_ready[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int i = 1; i < NUM_STAGES; i++)
            begin
                if (stage_ready[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    // A quotient that would need more than QB bits only ever saturates.
    always_ff @(posedge clk)
    begin
        if (stage_ready[0])
        begin
            rem_row_reg[0] <= num_row_in;
            rem_col_reg[0] <= num_col_in;
            div_reg[0]     <= div_in;
            q_row_reg[0]   <= '0;
            q_col_reg[0]   <= '0;
            ovf_row_reg[0] <= num_row_in >= (div_in << QB);
            ovf_col_reg[0] <= num_col_in >= (div_in << QB);
            row_neg_reg[0] <= in_fit.row_neg;
            col_neg_reg[0] <= in_fit.col_neg;
            degen_reg[0]   <= in_fit.degenerate;
        end
    end

    // Restoring division, one quotient bit per stage, most significant first.
    for (genvar j = 0; j < QB; j++)
    begin : g_step
        localparam int K = QB - 1 - j;

        rem_t trial;
        logic take_row, take_col;

        assign trial    = div_reg[j] << K;
        assign take_row = rem_row_reg[j] >= trial;
        assign take_col = rem_col_reg[j] >= trial;

        always_ff @(posedge clk)
        begin
            if (stage_ready[j+1])
            begin
                rem_row_reg[j+1] <= take_row ? rem_row_reg[j] - trial : rem_row_reg[j];
                rem_col_reg[j+1] <= take_col ? rem_col_reg[j] - trial : rem_col_reg[j];
                q_row_reg[j+1]   <= q_row_reg[j] | (qpr_pkg::quo_t'(take_row) << K);
                q_col_reg[j+1]   <= q_col_reg[j] | (qpr_pkg::quo_t'(take_col) << K);
                div_reg[j+1]     <= div_reg[j];
                ovf_row_reg[j+1] <= ovf_row_reg[j];
                ovf_col_reg[j+1] <= ovf_col_reg[j];
                row_neg_reg[j+1] <= row_neg_reg[j];
                col_neg_reg[j+1] <= col_neg_reg[j];
                degen_reg[j+1]   <= degen_reg[j];
            end
        end
    end

    always_comb
    begin
        if (degen_reg[QB])
        begin
            word_next.offset_row = '0;
            word_next.offset_col = '0;
            word_next.degenerate = 1'b1;
        end
        else
        begin
            word_next.offset_row = sat_offset(q_row_reg[QB], ovf_row_reg[QB], row_neg_reg[QB]);
            word_next.offset_col = sat_offset(q_col_reg[QB], ovf_col_reg[QB], col_neg_reg[QB]);
            word_next.degenerate = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready[NUM_STAGES-1])
        begin
            word_reg <= word_next;
        end
    end

endmodule

### design/quadratic_peak_refine_3x3.sv
`timescale 1ns / 1ps

// Sub-grid peak refinement on a 3x3 grid of signed 16-bit samples whose center is
// the coarse maximum. The block fits a least-squares paraboloid in exact integer
// arithmetic and returns the row and column offsets of its stationary point in
// signed fixed point with OFFSET_FRAC_BITS fraction bits (Q2.14 by default),
// truncated toward zero and saturated to 16 bits. When the magnitude of the
// scaled determinant is zero or below the degenerate limit register (reset 1),
// both offsets are zero and the degenerate flag is set. One grid word is taken
// every cycle while grid_stall is low; most pipeline stages belong to the
// 17-step restoring divider that resolves one quotient bit per stage (the other
// eight stages form moments, coefficients, products, the determinant and the
// saturated output). A stalled result does not stop the pipeline from filling
// its empty stages. Write the limit only while no word is in flight.
module quadratic_peak_refine_3x3 #(
    parameter int OFFSET_FRAC_BITS = 14
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  qpr_pkg::limit_t       cfg_wdata,
    input  logic                  grid_valid,
    output logic                  grid_stall,
    input  qpr_pkg::grid_word_t   grid,
    output logic                  peak_valid,
    input  logic                  peak_stall,
    output qpr_pkg::peak_word_t   peak
);

    qpr_pkg::limit_t    limit_reg;

    logic               front_ready;
    logic               prod_valid, combine_ready;
    qpr_pkg::prod_set_t prod;
    logic               fit_valid, divider_ready;
    qpr_pkg::fit_t      fit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= qpr_pkg::limit_t'(1);
        end
        else if (cfg_we)
        begin
            limit_reg <= cfg_wdata;
        end
    end

    assign grid_stall = !front_ready;

    qpr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (grid_valid),
        .in_ready  (front_ready),
        .in_word   (grid),
        .out_valid (prod_valid),
        .out_ready (combine_ready),
        .out_prod  (prod)
    );

    qpr_combine u_combine (
        .clk       (clk),
        .rst_n     (rst_n),
        .limit     (limit_reg),
        .in_valid  (prod_valid),
        .in_ready  (combine_ready),
        .in_prod   (prod),
        .out_valid (fit_valid),
        .out_ready (divider_ready),
        .out_fit   (fit)
    );

    qpr_divider #(
        .FRAC_BITS (OFFSET_FRAC_BITS)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fit_valid),
        .in_ready  (divider_ready),
        .in_fit    (fit),
        .out_valid (peak_valid),
        .out_ready (!peak_stall),
        .out_word  (peak)
    );

endmodule
